FILE: rtl/core/ssm_pkg.sv
// shared types, constants and helper functions for the seven-segment serial driver
package ssm_pkg;

  localparam int NumDigits = 4;
  localparam int FrameBits = 16;
  localparam int CountW = $clog2(FrameBits);
  localparam int IndexW = $clog2(NumDigits);
  localparam int FifoDepth = 2;

  localparam logic [13:0] MaxShown = 14'd9999;
  localparam logic [7:0] PeriodReset = 8'd2;
  localparam logic [7:0] TickMax = 8'd255;

  localparam logic [13:0] Thousand = 14'd1000;
  localparam logic [13:0] Hundred = 14'd100;
  localparam logic [13:0] Ten = 14'd10;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rem;
  } split_t;

  // one refresh frame handed from the front part to the serialiser
  typedef struct packed {
    logic                 valid;
    logic [FrameBits-1:0] word;
  } frame_push_t;

  // segment patterns, bit 0 = segment a ... bit 6 = segment g
  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'b0011_1111;
      4'd1:    g = 8'b0000_0110;
      4'd2:    g = 8'b0101_1011;
      4'd3:    g = 8'b0100_1111;
      4'd4:    g = 8'b0110_0110;
      4'd5:    g = 8'b0110_1101;
      4'd6:    g = 8'b0111_1101;
      4'd7:    g = 8'b0000_0111;
      4'd8:    g = 8'b0111_1111;
      4'd9:    g = 8'b0110_1111;
      default: g = 8'b0000_0000;
    endcase
    return g;
  endfunction

  // one decimal digit by parallel compare against the nine multiples of scale
  function automatic split_t digit_split(input logic [13:0] r, input logic [13:0] scale);
    split_t     res;
    logic [13:0] step;
    res.digit = 4'd0;
    res.rem = r;
    step = 14'd0;
    for (int k = 1; k <= 9; k++) begin
      step = step + scale;
      if (r >= step) begin
        res.digit = 4'(k);
        res.rem = r - step;
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/ssm_front.sv
// front pipeline: value split into digits, display buffer, tick counting and frame build
module ssm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,
  input  logic                       s_tuser,
  input  logic                       cfg_wen,
  input  logic [7:0]                 cfg_wdata,
  input  logic                       fifo_full,
  output ssm_pkg::frame_push_t       push
);

  logic adv;

  // stage 1: saturated value
  logic        v1;
  logic        func1;
  logic [13:0] val1;
  // stage 2: thousands digit taken off
  logic        v2;
  logic        func2;
  logic [3:0]  dth2;
  logic [9:0]  rem2;
  // stage 3: hundreds digit taken off, commit happens here
  logic        v3;
  logic        func3;
  logic [3:0]  dth3;
  logic [3:0]  dhu3;
  logic [6:0]  rem3;

  logic [7:0]                    refresh_period;
  logic [7:0]                    segment_store [ssm_pkg::NumDigits];
  logic [ssm_pkg::IndexW-1:0]    digit_index;
  logic [7:0]                    ticks;

  ssm_pkg::split_t sp_th;
  ssm_pkg::split_t sp_hu;
  ssm_pkg::split_t sp_te;
  logic [7:0]      ticks_inc;
  logic            do_load;
  logic            do_tick;
  logic            emit;

  assign adv = !(v3 && (func3 == ssm_pkg::FUNC_TICK) && fifo_full);
  assign s_tready = adv;

  assign sp_th = ssm_pkg::digit_split(val1, ssm_pkg::Thousand);
  assign sp_hu = ssm_pkg::digit_split({4'd0, rem2}, ssm_pkg::Hundred);
  assign sp_te = ssm_pkg::digit_split({7'd0, rem3}, ssm_pkg::Ten);

  assign do_load = adv && v3 && (func3 == ssm_pkg::FUNC_LOAD);
  assign do_tick = adv && v3 && (func3 == ssm_pkg::FUNC_TICK);
  assign ticks_inc = (ticks == ssm_pkg::TickMax) ? ticks : ticks + 8'd1;
  assign emit = do_tick && (ticks_inc >= refresh_period);

  assign push.valid = emit;
  assign push.word = {~segment_store[digit_index], 8'd1 << digit_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1 <= s_tuser;
      val1 <= (s_tdata > 16'(ssm_pkg::MaxShown)) ? ssm_pkg::MaxShown : s_tdata[13:0];
      func2 <= func1;
      dth2 <= sp_th.digit;
      rem2 <= sp_th.rem[9:0];
      func3 <= func2;
      dth3 <= dth2;
      dhu3 <= sp_hu.digit;
      rem3 <= sp_hu.rem[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period <= ssm_pkg::PeriodReset;
    end else if (cfg_wen) begin
      refresh_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ssm_pkg::NumDigits; i++) begin
        segment_store[i] <= 8'd0;
      end
    end else if (do_load) begin
      segment_store[0] <= ssm_pkg::glyph(dth3);
      segment_store[1] <= ssm_pkg::glyph(dhu3);
      segment_store[2] <= ssm_pkg::glyph(sp_te.digit);
      segment_store[3] <= ssm_pkg::glyph(sp_te.rem[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_index <= '0;
      ticks <= 8'd0;
    end else if (emit) begin
      digit_index <= digit_index + 1'b1;
      ticks <= 8'd0;
    end else if (do_tick) begin
      ticks <= ticks_inc;
    end
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (rst) emit |=> ticks == 8'd0)
    else $error("tick count not cleared after refresh");
  a_emit_steps: assert property (@(posedge clk) disable iff (rst)
    emit |=> digit_index == $past(digit_index) + 1'b1)
    else $error("digit index did not advance after refresh");
  a_load_lit: assert property (@(posedge clk) disable iff (rst)
    do_load |=> segment_store[0] != 8'd0 && segment_store[3] != 8'd0)
    else $error("load left a blank digit");

endmodule

FILE: rtl/core/ssm_fifo.sv
// two-entry frame queue between the front pipeline and the serialiser
module ssm_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  ssm_pkg::frame_push_t                push,
  output logic                                full,
  input  logic                                pop,
  output logic                                empty,
  output logic [ssm_pkg::FrameBits-1:0]       head
);

  localparam int PtrW = $clog2(ssm_pkg::FifoDepth);

  logic [ssm_pkg::FrameBits-1:0] entries [ssm_pkg::FifoDepth];
  logic [PtrW-1:0]               wr_ptr;
  logic [PtrW-1:0]               rd_ptr;
  logic [PtrW:0]                 fill;

  assign full = (fill == (PtrW + 1)'(ssm_pkg::FifoDepth));
  assign empty = (fill == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push.valid) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push.valid |-> !full)
    else $error("frame pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("frame popped from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PtrW + 1)'(ssm_pkg::FifoDepth))
    else $error("queue fill count out of range");

endmodule

FILE: rtl/core/ssm_back.sv
// serialiser: shifts each 16-bit frame out msb first, one bit per item
module ssm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fifo_empty,
  input  logic [ssm_pkg::FrameBits-1:0]  fifo_head,
  output logic                           fifo_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,
  output logic                           m_tlast
);

  logic                           busy;
  logic [ssm_pkg::FrameBits-1:0]  shreg;
  logic [ssm_pkg::CountW-1:0]     bit_cnt;
  logic                           last_bit;
  logic                           take;

  assign last_bit = (bit_cnt == ssm_pkg::CountW'(ssm_pkg::FrameBits - 1));
  assign take = m_tvalid && m_tready;
  assign fifo_pop = !fifo_empty && (!busy || (take && last_bit));

  assign m_tvalid = busy;
  assign m_tlast = last_bit;
  assign m_tdata = {7'd0, shreg[ssm_pkg::FrameBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bit_cnt <= '0;
    end else if (fifo_pop) begin
      busy <= 1'b1;
      bit_cnt <= '0;
    end else if (take) begin
      if (last_bit) begin
        busy <= 1'b0;
      end
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      shreg <= fifo_head;
    end else if (take) begin
      shreg <= {shreg[ssm_pkg::FrameBits-2:0], 1'b0};
    end
  end

endmodule

FILE: rtl/core/seven_segment_mux_serial_driver_core.sv
// top level of the multiplexed seven-segment serial driver
// Items are taken one per clock through a three-stage front pipeline. The
// first stage saturates a load value at 9999, the second takes off the
// thousands digit, and the third takes off the hundreds, tens and units and
// updates the four-digit display buffer. A tick item is counted in the last
// stage and, once refresh_period ticks have passed, the frame (inverted segment
// byte of the current digit, then the one-hot digit select byte) is queued in a
// two-frame queue. The serialiser sends each frame as 16 output items, one per
// cycle while m_tready is high, msb first, with tlast marking the sixteenth bit
// as the latch strobe. A refreshing tick thus costs a whole frame on the
// one-bit serial port; ticks and loads that do not refresh pass at one per
// cycle, and input only stalls while a tick sits in the last stage and the
// frame queue is full. The display buffer and counters are cleared by rst.
module seven_segment_mux_serial_driver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic        s_tuser,   // [0] func: 0 tick, 1 load
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata, // refresh_period
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] serial_bit, [7:1] zero
  output logic        m_tlast
);

  ssm_pkg::frame_push_t              push;
  logic                              fifo_full;
  logic                              fifo_empty;
  logic                              fifo_pop;
  logic [ssm_pkg::FrameBits-1:0]     fifo_head;

  ssm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .fifo_full (fifo_full),
    .push      (push)
  );

  ssm_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .empty (fifo_empty),
    .head  (fifo_head)
  );

  ssm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .fifo_head  (fifo_head),
    .fifo_pop   (fifo_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
